/* rtl/rnta_pkg.sv */
`default_nettype none

package rnta_pkg;

  localparam int unsigned VALUE_BITS  = 64;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_BITS);

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_UPPER = 8'h41;
  localparam logic [7:0] ASCII_LOWER = 8'h61;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  radix;
    logic        upper_case;
    logic        negative;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        minus_before;
    logic [6:0]  digit_count;
    logic        last;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic [4:0]            base;
    logic                  upper_case;
    logic                  negative;
  } cmd_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {4'd0, d};
    end else if (upper) begin
      c = ASCII_UPPER + {4'd0, d - 4'd10};
    end else begin
      c = ASCII_LOWER + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/rnta_front.sv */
`default_nettype none

module rnta_front import rnta_pkg::*; (
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          push_o,
  output cmd_t          cmd_o,
  input  wire logic     full_i
);

  logic [4:0] base;

  // Clamp the base into 2..16
  always_comb begin
    if (in_item_i.radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (in_item_i.radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = in_item_i.radix;
    end
  end

  assign in_stall_o        = full_i;
  assign push_o            = in_valid_i & ~full_i;
  assign cmd_o.mag         = in_item_i.value[VALUE_BITS-1:0];
  assign cmd_o.base        = base;
  assign cmd_o.upper_case  = in_item_i.upper_case;
  assign cmd_o.negative    = in_item_i.negative;

endmodule

`default_nettype wire

/* rtl/rnta_queue.sv */
`default_nettype none

module rnta_queue import rnta_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  wire logic pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (!push_i && do_pop) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rnta_back.sv */
`default_nettype none

module rnta_back import rnta_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SEND
  } state_e;

  state_e                state_q;
  logic [VALUE_BITS-1:0] div_q;
  logic [DIGIT_W-1:0]    rem_q;
  logic [4:0]            base_q;
  logic                  upper_q;
  logic                  neg_q;
  logic [BIT_CNT_W-1:0]  bit_q;
  logic [COUNT_W-1:0]    cnt_q;
  logic [STORE_AW-1:0]   rd_idx_q;
  logic                  first_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic [DIGIT_W-1:0]    store_q [STORE_DEPTH];
  logic [DIGIT_W-1:0]    rd_data_q;

  logic [4:0]            rem_sh;
  logic                  ge;
  logic [DIGIT_W-1:0]    rem_d;
  logic [VALUE_BITS-1:0] div_d;
  logic                  wr_en;
  logic                  out_free;
  logic                  send;

  // One restoring step: shift in the next dividend bit, subtract the base if it fits
  always_comb begin
    rem_sh = {rem_q, div_q[VALUE_BITS-1]};
    ge     = (rem_sh >= base_q);
    rem_d  = ge ? DIGIT_W'(rem_sh - base_q) : rem_sh[DIGIT_W-1:0];
    div_d  = {div_q[VALUE_BITS-2:0], ge};
  end

  assign wr_en       = (state_q == ST_DIV) && (bit_q == '0);
  assign cmd_pop_o   = (state_q == ST_IDLE);
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign send        = (state_q == ST_SEND) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[cnt_q[STORE_AW-1:0]] <= rem_d;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= store_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_q       <= '0;
      rem_q       <= '0;
      base_q      <= RADIX_MIN;
      upper_q     <= 1'b0;
      neg_q       <= 1'b0;
      bit_q       <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !send) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            div_q   <= cmd_i.mag;
            rem_q   <= '0;
            base_q  <= cmd_i.base;
            upper_q <= cmd_i.upper_case;
            neg_q   <= cmd_i.negative;
            bit_q   <= BIT_CNT_W'(VALUE_BITS - 1);
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (bit_q == '0) begin
            // Digit done: stop on a zero quotient or a full store
            cnt_q <= cnt_q + COUNT_W'(1);
            if (div_d == '0 || cnt_q == COUNT_W'(STORE_DEPTH - 1)) begin
              rd_idx_q <= cnt_q[STORE_AW-1:0];
              first_q  <= 1'b1;
              state_q  <= ST_READ;
            end else begin
              div_q <= div_d;
              rem_q <= '0;
              bit_q <= BIT_CNT_W'(VALUE_BITS - 1);
            end
          end else begin
            div_q <= div_d;
            rem_q <= rem_d;
            bit_q <= bit_q - BIT_CNT_W'(1);
          end
        end
        ST_READ: begin
          state_q <= ST_SEND;
        end
        ST_SEND: begin
          if (send) begin
            out_valid_q        <= 1'b1;
            out_q.char_code    <= digit_char(rd_data_q, upper_q);
            out_q.minus_before <= neg_q & first_q;
            out_q.digit_count  <= cnt_q;
            out_q.last         <= (rd_idx_q == '0);
            first_q            <= 1'b0;
            if (rd_idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q - STORE_AW'(1);
              state_q  <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/radix_number_to_ascii.sv */
// Radix number to ASCII digits.
// Input channel (in_valid_i / in_stall_o / in_item_i): one item carries an
// unsigned magnitude, a base (clamped to 2..16), a case select and a sign flag.
// Output channel (out_valid_o / out_stall_i / out_item_o): one item per digit,
// most significant first, each with its character, the digit count, a last
// marker, and on the first digit a flag for a leading minus sign.
// A two-entry queue sits between the accepting front and the converter, so up
// to two further items are taken while one is being converted.
// Each digit is produced by a bit-serial restoring divider, then the digits
// are read back from the digit store and sent one by one, most significant
// first. The first digit appears only after all divisions finish.
// A stall on the output holds the current digit in the output register and
// pauses read-back; the next item is taken only after the last digit is sent.
// Reset clears the queue, the converter state and the output valid; the digit
// store needs no clearing since every entry is written before it is read.
`default_nettype none

module radix_number_to_ascii import rnta_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  rnta_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  rnta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  rnta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
